>>> sv/sssr_pkg.sv
package sssr_pkg;

  localparam int MAX_DIGITS = 16;
  localparam int MAX_SCALE  = 10;

  localparam int IDX_W   = $clog2(MAX_DIGITS);
  localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
  localparam int ROW_W   = $clog2(2 * MAX_SCALE + 3);
  localparam int COL_W   = $clog2(MAX_SCALE + 3);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_DASH  = 7'd45;
  localparam logic [6:0] CH_BAR   = 7'd124;
  localparam logic [6:0] CH_NL    = 7'd10;

  // segment bits a..g in bits 0..6
  localparam int SEG_A = 0;
  localparam int SEG_B = 1;
  localparam int SEG_C = 2;
  localparam int SEG_D = 3;
  localparam int SEG_E = 4;
  localparam int SEG_F = 5;
  localparam int SEG_G = 6;

  typedef struct packed {
    logic       operation;
    logic [3:0] digit_value;
    logic       start_new;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       end_of_line;
    logic       end_of_frame;
  } out_item_t;

  function automatic logic [6:0] glyph_segs(input logic [3:0] d);
    logic [6:0] m;
    unique case (d)
      4'd0:    m = 7'h3F;
      4'd1:    m = 7'h06;
      4'd2:    m = 7'h5B;
      4'd3:    m = 7'h4F;
      4'd4:    m = 7'h66;
      4'd5:    m = 7'h6D;
      4'd6:    m = 7'h7D;
      4'd7:    m = 7'h07;
      4'd8:    m = 7'h7F;
      4'd9:    m = 7'h6F;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

endpackage

>>> sv/scaled_seven_segment_text_renderer_core.sv
// channel   dir   handshake             payload
// in        in    in_valid / in_ready   in_data    (operation, digit_value, start_new)
// out       out   out_valid / out_ready out_data   (char_code, end_of_line, end_of_frame)
// cfg       in    cfg_valid / cfg_ready cfg_data   (scale_size)
//
// every item is handled in the cycle it is accepted; one item per cycle
// the single result register sets the rate: in_ready drops only while a result is stalled
// a load or a tick on an empty string gives no result
// rst clears digit count, scan position and result valid; scale resets to 1
// cfg_ready is always high
module scaled_seven_segment_text_renderer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sssr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sssr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);
  import sssr_pkg::*;

  logic [3:0]         digit_store [MAX_DIGITS];
  logic [COUNT_W-1:0] digit_count;
  logic [ROW_W-1:0]   scan_row;
  logic [COUNT_W-1:0] scan_digit;
  logic [COL_W-1:0]   scan_column;
  logic [3:0]         scale_size;

  logic [COUNT_W-1:0] digit_count_next;
  logic [ROW_W-1:0]   scan_row_next;
  logic [COUNT_W-1:0] scan_digit_next;
  logic [COL_W-1:0]   scan_column_next;
  logic               out_valid_next;
  out_item_t          out_data_next;

  logic               accept;
  logic [3:0]         s_eff;
  logic [ROW_W-1:0]   s_r;
  logic [ROW_W-1:0]   row_mid;
  logic [ROW_W-1:0]   row_last;
  logic [COL_W-1:0]   col_right;
  logic [COL_W-1:0]   col_space;
  logic               oob;
  logic [ROW_W-1:0]   pr;
  logic [COUNT_W-1:0] pd;
  logic [COL_W-1:0]   pc;
  logic [6:0]         segs;
  logic               left;
  logic               right;
  logic               mid;
  logic [6:0]         glyph_ch;
  logic               wr_en;
  logic [COUNT_W-1:0] wr_pos;

  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (scale_size == 4'd0) begin
      s_eff = 4'd1;
    end else if (scale_size > 4'(MAX_SCALE)) begin
      s_eff = 4'(MAX_SCALE);
    end else begin
      s_eff = scale_size;
    end
  end

  assign s_r       = ROW_W'(s_eff);
  assign row_mid   = s_r + ROW_W'(1);
  assign row_last  = s_r + s_r + ROW_W'(2);
  assign col_right = COL_W'(s_eff) + COL_W'(1);
  assign col_space = COL_W'(s_eff) + COL_W'(2);

  assign oob = (scan_row > row_last) || (scan_digit > digit_count) ||
               ((scan_digit < digit_count) && (scan_column > col_space));
  assign pr  = oob ? '0 : scan_row;
  assign pd  = oob ? '0 : scan_digit;
  assign pc  = oob ? '0 : scan_column;

  assign segs  = glyph_segs(digit_store[pd[IDX_W-1:0]]);
  assign left  = (pc == '0);
  assign right = (pc == col_right);
  assign mid   = !left && !right;

  always_comb begin
    glyph_ch = CH_SPACE;
    if (pr == '0) begin
      if (mid && segs[SEG_A]) glyph_ch = CH_DASH;
    end else if (pr == row_mid) begin
      if (mid && segs[SEG_G]) glyph_ch = CH_DASH;
    end else if (pr == row_last) begin
      if (mid && segs[SEG_D]) glyph_ch = CH_DASH;
    end else if (pr <= s_r) begin
      if ((left && segs[SEG_F]) || (right && segs[SEG_B])) glyph_ch = CH_BAR;
    end else begin
      if ((left && segs[SEG_E]) || (right && segs[SEG_C])) glyph_ch = CH_BAR;
    end
  end

  always_comb begin
    digit_count_next = digit_count;
    scan_row_next    = scan_row;
    scan_digit_next  = scan_digit;
    scan_column_next = scan_column;
    out_valid_next   = out_valid && !out_ready;
    out_data_next    = out_data;
    wr_en            = 1'b0;
    wr_pos           = in_data.start_new ? '0 : digit_count;
    if (accept) begin
      if (in_data.operation == OP_LOAD) begin
        if (in_data.start_new) begin
          scan_row_next    = '0;
          scan_digit_next  = '0;
          scan_column_next = '0;
        end
        if (in_data.start_new || (digit_count < COUNT_W'(MAX_DIGITS))) begin
          wr_en            = 1'b1;
          digit_count_next = wr_pos + COUNT_W'(1);
        end
      end else if (digit_count != '0) begin
        out_valid_next = 1'b1;
        if (pd == digit_count) begin
          out_data_next.char_code    = CH_NL;
          out_data_next.end_of_line  = 1'b1;
          out_data_next.end_of_frame = (pr == row_last);
          scan_digit_next            = '0;
          scan_column_next           = '0;
          scan_row_next              = (pr == row_last) ? '0 : pr + ROW_W'(1);
        end else begin
          out_data_next.char_code    = (pc == col_space) ? CH_SPACE : glyph_ch;
          out_data_next.end_of_line  = 1'b0;
          out_data_next.end_of_frame = 1'b0;
          scan_row_next              = pr;
          if (pc >= col_space) begin
            scan_column_next = '0;
            scan_digit_next  = pd + COUNT_W'(1);
          end else begin
            scan_column_next = pc + COL_W'(1);
            scan_digit_next  = pd;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      scan_row    <= '0;
      scan_digit  <= '0;
      scan_column <= '0;
      scale_size  <= 4'd1;
      out_valid   <= 1'b0;
    end else begin
      digit_count <= digit_count_next;
      scan_row    <= scan_row_next;
      scan_digit  <= scan_digit_next;
      scan_column <= scan_column_next;
      out_valid   <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        scale_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    if (wr_en) begin
      digit_store[wr_pos[IDX_W-1:0]] <= in_data.digit_value;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_W'(MAX_DIGITS))
    else $error("digit count above store depth");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    scan_column <= COL_W'(MAX_SCALE + 2))
    else $error("scan column beyond widest glyph cell");

  a_eof_eol: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_frame |-> out_data.end_of_line)
    else $error("end of frame without end of line");

  a_eol_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_line |-> out_data.char_code == CH_NL)
    else $error("row end is not a newline");

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.operation == OP_TICK && digit_count != '0 |=> out_valid)
    else $error("tick on loaded string gave no result");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.operation == OP_LOAD |=> !out_valid)
    else $error("load produced a result");

endmodule
